// File: hw/rtl/evad_pkg.sv
// types and constants shared by the energy voice detector
// no dependencies; imported by every module of the block
package evad_pkg;

   localparam int unsigned SampleW    = 16;
   localparam int unsigned ThreshW    = 15;
   localparam int unsigned FlenW      = 11;
   localparam int unsigned HangW      = 16;
   localparam int unsigned CsrIndexW  = 2;
   localparam int unsigned CsrDataW   = 16;
   localparam int unsigned MagW       = SampleW + 1;
   localparam int unsigned LenCmpW    = 13;

   localparam logic [ThreshW-1:0] ThreshReset = ThreshW'(500);
   localparam logic [FlenW-1:0]   FlenReset   = FlenW'(320);
   localparam logic [HangW-1:0]   HangReset   = HangW'(500);

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_TICK   = 2'd1,
      OP_START  = 2'd2,
      OP_STOP   = 2'd3
   } opcode_type;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_FRAME_LEN = 2'd1,
      CSR_HANGOVER  = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      opcode_type               opcode;
      logic signed [SampleW-1:0] sample;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic speaking;
      logic frame_voiced;
   } rsp_type;

   typedef struct packed {
      logic [ThreshW-1:0] energy_threshold;
      logic [FlenW-1:0]   frame_length;
      logic [HangW-1:0]   hangover_ticks;
   } cfg_type;

endpackage

// File: hw/rtl/energy_vad_with_hangover_unit.sv
// from accept to result, ticks, start, stop and samples that leave the frame open pass
// the exec state and then the done state; a frame-closing sample also passes the
// multiply and compare states between them, the multiply being a shift-add loop on one adder
// one item at a time: the next beat is taken the cycle after the result is loaded into
// the output register, and the done state waits while the output is stalled
// reset (synchronous) clears state and restores the configuration defaults
module energy_vad_with_hangover_unit
   import evad_pkg::*;
#(
   parameter int unsigned MAX_FRAME = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata
);

   localparam int unsigned CntW = $clog2(MAX_FRAME + 1);
   localparam int unsigned SumW = $clog2(MAX_FRAME * 32768 + 1);
   localparam int unsigned AluW = SumW + 1;

   cfg_type cfg;

   state_type state_ff, state_in;
   logic               talking_ff, talking_in;
   logic [SumW-1:0]    sum_ff, sum_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [HangW-1:0]   hang_ff, hang_in;
   opcode_type         op_ff, op_in;
   logic [MagW-1:0]    mag_ff, mag_in;
   logic               last_ff, last_in;
   logic [AluW-1:0]    prod_ff, prod_in;
   logic [AluW-1:0]    mcand_ff, mcand_in;
   logic [CntW-1:0]    mplier_ff, mplier_in;
   logic               voiced_ff, voiced_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [AluW-1:0]    alu_a, alu_b, alu_result;
   logic               alu_cin, alu_cout;
   logic [MagW-1:0]    sample_ext;
   logic [LenCmpW-1:0] flen_ext, eff_len;
   logic [CntW-1:0]    count_next;
   logic               frame_close;
   logic               req_accept;

   evad_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   evad_alu #(.Width(AluW)) u_alu (
      .op_a      (alu_a),
      .op_b      (alu_b),
      .carry_in  (alu_cin),
      .result    (alu_result),
      .carry_out (alu_cout)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // sample sign-extended by one bit so that its magnitude, 32768 for the most negative value, fits
   assign sample_ext = {req_data.sample[SampleW-1], req_data.sample};

   // frame length clamped to 1 .. MAX_FRAME
   always_comb begin
      flen_ext = LenCmpW'(cfg.frame_length);
      if (flen_ext == '0) begin
         eff_len = LenCmpW'(1);
      end else if (flen_ext > LenCmpW'(MAX_FRAME)) begin
         eff_len = LenCmpW'(MAX_FRAME);
      end else begin
         eff_len = flen_ext;
      end
   end

   assign count_next  = count_ff + CntW'(1);
   assign frame_close = (LenCmpW'(count_next) >= eff_len) || last_ff;

   // operand selection for the shared adder
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_cin = 1'b0;
      unique case (state_ff)
         ST_EXEC: begin
            if (op_ff == OP_TICK) begin
               alu_a = AluW'(hang_ff);
               alu_b = '1;
            end else begin
               alu_a = AluW'(sum_ff);
               alu_b = AluW'(mag_ff);
            end
         end
         ST_MUL: begin
            alu_a = prod_ff;
            alu_b = mcand_ff;
         end
         ST_CMP: begin
            // sum - (threshold + 1) * count, carry out means sum >= product
            alu_a   = AluW'(sum_ff);
            alu_b   = ~prod_ff;
            alu_cin = 1'b1;
         end
         ST_IDLE, ST_DONE: begin
            alu_a = '0;
         end
         default: alu_a = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      talking_in   = talking_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      hang_in      = hang_ff;
      op_in        = op_ff;
      mag_in       = mag_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      voiced_in    = voiced_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in     = req_data.opcode;
               mag_in    = req_data.sample[SampleW-1] ? (MagW'(0) - sample_ext) : sample_ext;
               last_in   = req_data.last;
               voiced_in = 1'b0;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            unique case (op_ff)
               OP_SAMPLE: begin
                  if (talking_ff) begin
                     sum_in   = alu_result[SumW-1:0];
                     count_in = count_next;
                     if (frame_close) begin
                        prod_in   = '0;
                        mcand_in  = AluW'(cfg.energy_threshold) + AluW'(1);
                        mplier_in = count_next;
                        state_in  = ST_MUL;
                     end
                  end
               end
               OP_TICK: begin
                  if (hang_ff != '0) begin
                     hang_in = alu_result[HangW-1:0];
                  end
               end
               OP_START: begin
                  talking_in = 1'b1;
                  hang_in    = '0;
                  sum_in     = '0;
                  count_in   = '0;
               end
               OP_STOP: begin
                  talking_in = 1'b0;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_MUL: begin
            // shift-add multiply, one multiplier bit per cycle
            if (mplier_ff == '0) begin
               state_in = ST_CMP;
            end else begin
               if (mplier_ff[0]) begin
                  prod_in = alu_result;
               end
               mcand_in  = {mcand_ff[AluW-2:0], 1'b0};
               mplier_in = mplier_ff >> 1;
            end
         end
         ST_CMP: begin
            voiced_in = alu_cout;
            if (alu_cout) begin
               hang_in = cfg.hangover_ticks;
            end
            sum_in   = '0;
            count_in = '0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.speaking     = talking_ff && (hang_ff != '0);
               rsp_data_in.frame_voiced = voiced_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         talking_ff   <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         hang_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         talking_ff   <= talking_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         hang_ff      <= hang_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      mag_ff      <= mag_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      voiced_ff   <= voiced_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: hw/rtl/evad_alu.sv
// shared adder of the voice detector: a + b + carry in, with carry out
// depends on evad_pkg only for house consistency
module evad_alu
   import evad_pkg::*;
#(
   parameter int unsigned Width = 27
) (
   input  logic [Width-1:0] op_a,
   input  logic [Width-1:0] op_b,
   input  logic             carry_in,
   output logic [Width-1:0] result,
   output logic             carry_out
);

   logic [Width:0] full_sum;

   assign full_sum  = {1'b0, op_a} + {1'b0, op_b} + {{Width{1'b0}}, carry_in};
   assign result    = full_sum[Width-1:0];
   assign carry_out = full_sum[Width];

endmodule

// File: hw/rtl/evad_csr.sv
// configuration registers of the voice detector
// depends on evad_pkg for cfg_type, register indexes and reset values
module evad_csr
   import evad_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata,
   output logic                 csr_ready,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_THRESHOLD: cfg_in.energy_threshold = csr_wdata[ThreshW-1:0];
            CSR_FRAME_LEN: cfg_in.frame_length     = csr_wdata[FlenW-1:0];
            CSR_HANGOVER:  cfg_in.hangover_ticks   = csr_wdata[HangW-1:0];
            CSR_UNUSED:    cfg_in = cfg_ff;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.energy_threshold <= ThreshReset;
         cfg_ff.frame_length     <= FlenReset;
         cfg_ff.hangover_ticks   <= HangReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/evad_checker.sv
// port-level checks of the voice detector, bound to the top level
// depends on evad_pkg for the payload types
module evad_checker
   import evad_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a beat taken makes the block busy on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block took a beat but did not go busy");

   // a new result only appears at the end of work on an item
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while the block was idle");

   // no result in the cycle straight after a beat is taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && !req_stall))
      else $error("result appeared without any work cycle");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed or dropped");

endmodule

bind energy_vad_with_hangover_unit evad_checker u_evad_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: verif/evad_result_checker.sv
`timescale 1ns / 100ps
// result checker for the energy voice detector: follows the request, result and
// csr channels, predicts every result beat and compares it; depends on evad_pkg
module evad_result_checker
   import evad_pkg::*;
#(
   parameter int unsigned MAX_FRAME = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata,
   output int                   pending,
   output int                   errors
);

   cfg_type             vad_cfg;
   logic                talking;
   logic [25:0]         energy_sum;
   logic [LenCmpW-1:0]  frame_count;
   logic [HangW-1:0]    hang_left;
   rsp_type             expected_flags[$];
   int                  mismatches = 0;

   // abs of the most negative sample is 32768, hence one extra bit
   function automatic logic [MagW-1:0] magnitude(input logic [SampleW-1:0] s);
      if (s[SampleW-1]) begin
         return (MagW'(1) << SampleW) - MagW'(s);
      end
      return MagW'(s);
   endfunction

   function automatic int frame_target();
      if (vad_cfg.frame_length == '0) begin
         return 1;
      end
      if (vad_cfg.frame_length > MAX_FRAME) begin
         return MAX_FRAME;
      end
      return int'(vad_cfg.frame_length);
   endfunction

   function automatic rsp_type vad_decision(input req_type item);
      rsp_type     flags;
      logic [25:0] mean;
      flags = '0;
      case (item.opcode)
         OP_SAMPLE: begin
            // samples are dropped while not talking
            if (talking) begin
               energy_sum  = energy_sum + magnitude(item.sample);
               frame_count = frame_count + 1'b1;
               if (frame_count >= frame_target() || item.last) begin
                  mean = energy_sum / frame_count;
                  if (mean > vad_cfg.energy_threshold) begin
                     flags.frame_voiced = 1'b1;
                     hang_left          = vad_cfg.hangover_ticks;
                  end
                  energy_sum  = '0;
                  frame_count = '0;
               end
            end
         end
         OP_TICK: begin
            if (hang_left != '0) begin
               hang_left = hang_left - 1'b1;
            end
         end
         OP_START: begin
            talking     = 1'b1;
            hang_left   = '0;
            energy_sum  = '0;
            frame_count = '0;
         end
         OP_STOP: begin
            // partial frame is kept until the next start
            talking = 1'b0;
         end
         default: begin
         end
      endcase
      flags.speaking = talking && (hang_left != '0);
      return flags;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         vad_cfg.energy_threshold = ThreshReset;
         vad_cfg.frame_length     = FlenReset;
         vad_cfg.hangover_ticks   = HangReset;
         talking                  = 1'b0;
         energy_sum               = '0;
         frame_count              = '0;
         hang_left                = '0;
         expected_flags.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_flags.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: result beat with nothing expected: speaking=%b frame_voiced=%b",
                           $realtime, rsp_data.speaking, rsp_data.frame_voiced);
               end
            end else begin
               want = expected_flags.pop_front();
               if (rsp_data.speaking !== want.speaking
                   || rsp_data.frame_voiced !== want.frame_voiced) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: mismatch speaking exp %b got %b, frame_voiced exp %b got %b",
                              $realtime, want.speaking, rsp_data.speaking,
                              want.frame_voiced, rsp_data.frame_voiced);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_THRESHOLD: vad_cfg.energy_threshold = csr_wdata[ThreshW-1:0];
               CSR_FRAME_LEN: vad_cfg.frame_length     = csr_wdata[FlenW-1:0];
               CSR_HANGOVER:  vad_cfg.hangover_ticks   = csr_wdata[HangW-1:0];
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_flags.push_back(vad_decision(req_data));
         end
      end
      pending <= expected_flags.size();
      errors  <= mismatches;
   end

endmodule

// File: verif/tb_energy_vad_with_hangover_unit.sv
`timescale 1ns / 100ps
// regression top for energy_vad_with_hangover_unit: clock, reset, stimulus and verdict
// depends on evad_pkg, the unit itself and evad_result_checker
module tb_energy_vad_with_hangover_unit;
   import evad_pkg::*;

   localparam int unsigned MAX_FRAME = 1024;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CsrIndexW-1:0] csr_index;
   logic [CsrDataW-1:0]  csr_wdata;
   int                   pending;
   int                   errors;
   int                   burst_left;

   energy_vad_with_hangover_unit #(.MAX_FRAME(MAX_FRAME)) dut (.*);

   evad_result_checker #(.MAX_FRAME(MAX_FRAME)) checker_i (.*);

   always #5 clock = ~clock;

   // receiver back-pressure: stretches of no stall, light stall and heavy stall
   initial begin
      int stall_pct;
      rsp_stall = 1'b0;
      forever begin
         stall_pct = $urandom_range(0, 2) * 35;
         repeat ($urandom_range(20, 200)) begin
            @(posedge clock);
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   initial begin
      #10_000_000;
      $display("energy_vad_with_hangover_unit regression: fail");
      $finish;
   end

   function automatic req_type beat_of(input opcode_type op, input logic [SampleW-1:0] s,
                                       input logic last);
      req_type item;
      item.opcode = op;
      item.sample = s;
      item.last   = last;
      return item;
   endfunction

   function automatic logic [SampleW-1:0] pick_sample(input int cap);
      int mag;
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom);
         default: begin
            mag = $urandom_range(0, cap);
            return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
         end
      endcase
   endfunction

   // bursts of random length; between bursts valid may drop for a random gap
   task automatic send_item(input req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 7);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      burst_left--;
   endtask

   // let the current edge pass first so that a beat taken at it is already counted
   task automatic wait_for_results();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic csr_beat(input csr_index_type idx, input logic [CsrDataW-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_settings(input logic [CsrDataW-1:0] thr, input logic [CsrDataW-1:0] flen,
                                 input logic [CsrDataW-1:0] hang);
      wait_for_results();
      csr_beat(CSR_THRESHOLD, thr);
      csr_beat(CSR_FRAME_LEN, flen);
      csr_beat(CSR_HANGOVER, hang);
      csr_valid <= 1'b0;
   endtask

   // mostly start-led talk spurts with random content, some noise beats
   task automatic run_phase(input int thr, input int quota);
      int sent;
      int len;
      int cap;
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(0, 29) == 0) begin
            wait_for_results();
         end
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               send_item(beat_of(opcode_type'($urandom_range(0, 3)), 16'($urandom),
                                 1'($urandom)));
               sent++;
            end
         end else begin
            // amplitude spread around the threshold so both verdicts turn up
            cap = $urandom_range(thr / 2, thr * 3 + 2);
            if (cap > 32768) begin
               cap = 32768;
            end
            send_item(beat_of(OP_START, 16'($urandom), 1'($urandom)));
            len = $urandom_range(4, 60);
            repeat (len) begin
               if ($urandom_range(0, 99) < 15) begin
                  send_item(beat_of(OP_TICK, 16'($urandom), 1'($urandom)));
               end else begin
                  send_item(beat_of(OP_SAMPLE, pick_sample(cap), $urandom_range(0, 19) == 0));
               end
            end
            sent += len + 1;
            if ($urandom_range(0, 1)) begin
               send_item(beat_of(OP_STOP, 16'($urandom), 1'($urandom)));
               sent++;
               // after stop ticks still count down and samples are dropped
               repeat ($urandom_range(0, 3)) begin
                  send_item(beat_of($urandom_range(0, 1) ? OP_TICK : OP_SAMPLE,
                                    pick_sample(cap), 1'($urandom)));
                  sent++;
               end
            end
         end
      end
   endtask

   initial begin
      logic [CsrDataW-1:0] thr;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_THRESHOLD;
      csr_wdata  = '0;
      burst_left = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed, on the reset settings (threshold 500, frame 320, hangover 500)
      send_item(beat_of(OP_SAMPLE, 16'h7fff, 1'b1));
      send_item(beat_of(OP_TICK, 16'h0000, 1'b0));
      send_item(beat_of(OP_STOP, 16'hffff, 1'b1));
      send_item(beat_of(OP_START, 16'h0000, 1'b0));
      send_item(beat_of(OP_SAMPLE, 16'h7fff, 1'b0));
      send_item(beat_of(OP_SAMPLE, 16'h8000, 1'b1));
      send_item(beat_of(OP_TICK, 16'h5555, 1'b1));
      send_item(beat_of(OP_SAMPLE, 16'h0000, 1'b1));
      send_item(beat_of(OP_SAMPLE, 16'd501, 1'b1));
      send_item(beat_of(OP_SAMPLE, -16'sd500, 1'b1));
      send_item(beat_of(OP_SAMPLE, -16'sd501, 1'b1));
      send_item(beat_of(OP_SAMPLE, 16'h8001, 1'b0));
      send_item(beat_of(OP_STOP, 16'haaaa, 1'b0));
      send_item(beat_of(OP_TICK, 16'h0000, 1'b0));
      send_item(beat_of(OP_SAMPLE, 16'h7fff, 1'b1));
      send_item(beat_of(OP_START, 16'hffff, 1'b1));
      send_item(beat_of(OP_SAMPLE, 16'h0001, 1'b1));
      send_item(beat_of(OP_STOP, 16'h0000, 1'b0));

      // zero threshold, zero frame length, zero hangover; bit 15 of threshold dropped
      write_settings(16'h8000, 16'h0000, 16'h0000);
      run_phase(0, 110);

      write_settings(16'd100, 16'd4, 16'd5);
      run_phase(100, 130);

      // top of every range; frame length above the maximum is clamped
      write_settings(16'hffff, 16'h07ff, 16'hffff);
      run_phase(32767, 100);

      // upper csr bits above the frame length field are dropped
      write_settings(16'd2000, 16'hf801, 16'd2);
      run_phase(2000, 110);

      write_settings(16'd300, 16'd1024, 16'd1000);
      run_phase(300, 100);

      repeat (2) begin
         thr = 16'($urandom_range(0, 3000));
         write_settings(thr, 16'($urandom_range(1, 24)), 16'($urandom_range(0, 40)));
         run_phase(thr, 110);
      end

      wait_for_results();
      repeat (20) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("energy_vad_with_hangover_unit regression: pass");
      end else begin
         $display("energy_vad_with_hangover_unit regression: fail");
      end
      $finish;
   end

endmodule

// File: energy_vad_with_hangover_unit.f
hw/rtl/evad_pkg.sv
hw/rtl/evad_alu.sv
hw/rtl/evad_csr.sv
hw/rtl/energy_vad_with_hangover_unit.sv
hw/rtl/evad_checker.sv
verif/evad_result_checker.sv
verif/tb_energy_vad_with_hangover_unit.sv
